### rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg - shared definitions for the point-in-polygon test core
// Coordinate widths, bus layouts, register indexes and the microcode ROM
// that sequences the crossing-number edge test.
// ----------------------------------------------------------------------------
package pip_pkg;

   // Coordinate format: signed Q16.16
   localparam int COORD_WIDTH    = 32;
   localparam int FIELD_WIDTH    = 32;
   localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
   localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;

   // Bus layouts
   localparam int REQ_DATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int CSR_IDX_WIDTH  = 1;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TEST_X = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TEST_Y = 1'b1;

   // Vertex counter saturates at three
   localparam logic [1:0] COUNT_MAX  = 2'd3;
   localparam logic [1:0] COUNT_FEW  = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   // Micro-operations driving the datapath
   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIFF,
      OP_MUL1,
      OP_MUL2,
      OP_CMP,
      OP_UPD,
      OP_EMIT
   } op_type;

   // Edge operand select: current edge or closing edge
   typedef enum logic {
      SEL_EDGE,
      SEL_CLOSE
   } sel_type;

   // Jump conditions; jump taken when true, else fall through
   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_EMPTY,
      C_NOT_LAST,
      C_OUT_FREE
   } cond_type;

   localparam int PROG_LEN = 14;
   localparam int PC_WIDTH = $clog2(PROG_LEN);

   typedef struct packed {
      op_type                op;
      sel_type               sel;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } ucode_type;

   // Program addresses
   localparam logic [PC_WIDTH-1:0] PC_WAIT   = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] PC_CHK    = PC_WIDTH'(1);
   localparam logic [PC_WIDTH-1:0] PC_E_DIFF = PC_WIDTH'(2);
   localparam logic [PC_WIDTH-1:0] PC_E_MUL1 = PC_WIDTH'(3);
   localparam logic [PC_WIDTH-1:0] PC_E_MUL2 = PC_WIDTH'(4);
   localparam logic [PC_WIDTH-1:0] PC_E_CMP  = PC_WIDTH'(5);
   localparam logic [PC_WIDTH-1:0] PC_UPD    = PC_WIDTH'(6);
   localparam logic [PC_WIDTH-1:0] PC_CHK2   = PC_WIDTH'(7);
   localparam logic [PC_WIDTH-1:0] PC_C_DIFF = PC_WIDTH'(8);
   localparam logic [PC_WIDTH-1:0] PC_C_MUL1 = PC_WIDTH'(9);
   localparam logic [PC_WIDTH-1:0] PC_C_MUL2 = PC_WIDTH'(10);
   localparam logic [PC_WIDTH-1:0] PC_C_CMP  = PC_WIDTH'(11);
   localparam logic [PC_WIDTH-1:0] PC_EMIT   = PC_WIDTH'(12);
   localparam logic [PC_WIDTH-1:0] PC_HOLD   = PC_WIDTH'(13);

   // Microcode ROM
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, sel: SEL_EDGE, cond: C_ALWAYS, target: PC_WAIT};
      unique case (pc)
         PC_WAIT:   w = '{op: OP_NOP,  sel: SEL_EDGE,  cond: C_NO_REQ,   target: PC_WAIT};
         PC_CHK:    w = '{op: OP_NOP,  sel: SEL_EDGE,  cond: C_EMPTY,    target: PC_UPD};
         PC_E_DIFF: w = '{op: OP_DIFF, sel: SEL_EDGE,  cond: C_NEXT,     target: PC_WAIT};
         PC_E_MUL1: w = '{op: OP_MUL1, sel: SEL_EDGE,  cond: C_NEXT,     target: PC_WAIT};
         PC_E_MUL2: w = '{op: OP_MUL2, sel: SEL_EDGE,  cond: C_NEXT,     target: PC_WAIT};
         PC_E_CMP:  w = '{op: OP_CMP,  sel: SEL_EDGE,  cond: C_NEXT,     target: PC_WAIT};
         PC_UPD:    w = '{op: OP_UPD,  sel: SEL_EDGE,  cond: C_NOT_LAST, target: PC_WAIT};
         PC_CHK2:   w = '{op: OP_NOP,  sel: SEL_CLOSE, cond: C_EMPTY,    target: PC_EMIT};
         PC_C_DIFF: w = '{op: OP_DIFF, sel: SEL_CLOSE, cond: C_NEXT,     target: PC_WAIT};
         PC_C_MUL1: w = '{op: OP_MUL1, sel: SEL_CLOSE, cond: C_NEXT,     target: PC_WAIT};
         PC_C_MUL2: w = '{op: OP_MUL2, sel: SEL_CLOSE, cond: C_NEXT,     target: PC_WAIT};
         PC_C_CMP:  w = '{op: OP_CMP,  sel: SEL_CLOSE, cond: C_NEXT,     target: PC_WAIT};
         PC_EMIT:   w = '{op: OP_EMIT, sel: SEL_CLOSE, cond: C_OUT_FREE, target: PC_WAIT};
         PC_HOLD:   w = '{op: OP_NOP,  sel: SEL_CLOSE, cond: C_ALWAYS,   target: PC_EMIT};
         default:   w = '{op: OP_NOP,  sel: SEL_EDGE,  cond: C_ALWAYS,   target: PC_WAIT};
      endcase
      return w;
   endfunction

   // Low COORD_WIDTH bits of a bus field
   function automatic coord_type to_coord(input logic [FIELD_WIDTH-1:0] v);
      logic [COORD_WIDTH+FIELD_WIDTH-1:0] t;
      t = {{COORD_WIDTH{1'b0}}, v};
      return coord_type'(t[COORD_WIDTH-1:0]);
   endfunction

   // Exact difference of two coordinates
   function automatic diff_type coord_sub(input coord_type a, input coord_type b);
      diff_type ae;
      diff_type be;
      ae = $signed({a[COORD_WIDTH-1], a});
      be = $signed({b[COORD_WIDTH-1], b});
      return ae - be;
   endfunction

endpackage

### rtl/point_in_polygon_test_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core - streamed crossing-number polygon test
// Vertices arrive one per transaction; each edge is tested against the query
// point by exact cross-multiplication, sequenced by a microcode ROM over one
// shared multiplier. The flagged last vertex also tests the closing edge and
// produces one result transaction.
// ----------------------------------------------------------------------------
// A vertex is taken only in the wait step, once the previous one is processed;
//   the single shared multiplier forms two products per edge.
// Last vertex: its edge and closing edge tests (unless it is the first), then emit.
// Next vertex is taken while a result still waits in the output register.
// Reset (synchronous, active high) clears query point, previous and first vertex,
//   vertex count, crossing parity and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core
   import pip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Vertex stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // vertex_x, vertex_y
   input  logic                      req_tlast,   // last_vertex
   // Result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // inside_res, too_few_vertices, zero pad
   // Register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [FIELD_WIDTH-1:0]    csr_data
);

   // Sequencer
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   ucode_type           uc;
   logic                jump;

   // Query point
   coord_type test_x_ff, test_x_in;
   coord_type test_y_ff, test_y_in;

   // Vertex state
   coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic      cur_last_ff, cur_last_in;
   logic      empty_ff, empty_in;
   logic      few_ff, few_in;
   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [1:0] count_ff, count_in;
   logic      inside_ff, inside_in;

   // Edge test datapath
   diff_type  opa_ff, opa_in, opb_ff, opb_in;
   prod_type  prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic      straddle_ff, straddle_in;
   logic      dy_neg_ff, dy_neg_in;
   coord_type xc, yc, xp, yp;
   prod_type  prod;
   logic      lt, eq, toggle;

   // Output register
   logic      rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_bits_ff, rsp_bits_in;
   logic      out_free, emit_go, accept;

   assign uc         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == PC_WAIT);
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign emit_go    = (uc.op == OP_EMIT) & out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-2){1'b0}}, rsp_bits_ff};

   // Jump condition and next step
   always_comb begin
      case (uc.cond)
         C_ALWAYS:   jump = 1'b1;
         C_NO_REQ:   jump = ~req_tvalid;
         C_EMPTY:    jump = empty_ff;
         C_NOT_LAST: jump = ~cur_last_ff;
         C_OUT_FREE: jump = out_free;
         default:    jump = 1'b0;
      endcase
      pc_in = jump ? uc.target : pc_ff + PC_WIDTH'(1);
   end

   // Edge end points: current edge runs prev -> cur, closing edge cur -> first
   always_comb begin
      if (uc.sel == SEL_CLOSE) begin
         xc = first_x_ff;
         yc = first_y_ff;
         xp = cur_x_ff;
         yp = cur_y_ff;
      end else begin
         xc = cur_x_ff;
         yc = cur_y_ff;
         xp = prev_x_ff;
         yp = prev_y_ff;
      end
   end

   // Shared multiplier on registered operands
   assign prod = opa_ff * opb_ff;

   // Exact product compare, sign of dy picks the direction
   assign lt     = prod1_ff < prod2_ff;
   assign eq     = prod1_ff == prod2_ff;
   assign toggle = straddle_ff & (dy_neg_ff ? (~lt & ~eq) : lt);

   // Datapath next state
   always_comb begin
      test_x_in    = test_x_ff;
      test_y_in    = test_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_last_in  = cur_last_ff;
      empty_in     = empty_ff;
      few_in       = few_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      count_in     = count_ff;
      inside_in    = inside_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      straddle_in  = straddle_ff;
      dy_neg_in    = dy_neg_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      // Register writes; an unknown index is dropped
      if (csr_valid) begin
         if (csr_index == CSR_TEST_X) begin
            test_x_in = to_coord(csr_data);
         end
         if (csr_index == CSR_TEST_Y) begin
            test_y_in = to_coord(csr_data);
         end
      end

      // Vertex transaction
      if (accept) begin
         cur_x_in    = to_coord(req_tdata[FIELD_WIDTH-1:0]);
         cur_y_in    = to_coord(req_tdata[REQ_DATA_WIDTH-1:FIELD_WIDTH]);
         cur_last_in = req_tlast;
         empty_in    = (count_ff == 2'd0);
         few_in      = (count_ff < COUNT_FEW);
      end

      case (uc.op)
         OP_DIFF: begin
            opa_in      = coord_sub(test_x_ff, xc);
            opb_in      = coord_sub(yp, yc);
            straddle_in = (yc > test_y_ff) != (yp > test_y_ff);
         end
         OP_MUL1: begin
            prod1_in  = prod;
            dy_neg_in = opb_ff[DIFF_WIDTH-1];
            opa_in    = coord_sub(xp, xc);
            opb_in    = coord_sub(test_y_ff, yc);
         end
         OP_MUL2: begin
            prod2_in = prod;
         end
         OP_CMP: begin
            inside_in = inside_ff ^ toggle;
         end
         OP_UPD: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            if (empty_ff) begin
               first_x_in = cur_x_ff;
               first_y_in = cur_y_ff;
            end
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 2'd1;
            end
         end
         OP_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = {few_ff, inside_ff & ~few_ff};
               inside_in    = 1'b0;
               count_in     = 2'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         test_x_ff    <= '0;
         test_y_ff    <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         count_ff     <= 2'd0;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         test_x_ff    <= test_x_in;
         test_y_ff    <= test_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         count_ff     <= count_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_last_ff <= cur_last_in;
      empty_ff    <= empty_in;
      few_ff      <= few_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      straddle_ff <= straddle_in;
      dy_neg_ff   <= dy_neg_in;
      rsp_bits_ff <= rsp_bits_in;
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the point-in-polygon test core
// Streams polygons vertex by vertex against a series of query points and
// checks every verdict against an in-bench crossing-number predictor that uses
// exact wide products. Random idle bursts on both streams; the query point is
// rewritten only between phases, once the core has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;
   import pip_pkg::*;

   localparam int          SETTLE_CYCLES = 20;
   localparam int          PHASE_VERTICES = 180;
   localparam int          RANDOM_PHASES = 8;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
   localparam logic [31:0] MAX_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] x;
      logic [FIELD_WIDTH-1:0] y;
      logic                   last;
   } vertex_type;

   typedef struct packed {
      logic in_poly;
      logic few;
   } verdict_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // vertex_x, vertex_y
   logic                      req_tlast = 1'b0; // last_vertex
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;        // inside_res, too_few_vertices, zero pad
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [FIELD_WIDTH-1:0]    csr_data = '0;

   vertex_type  pending_vertices[$];
   verdict_type expected_verdicts[$];
   bit       calm = 1'b0;
   bit       vtx_taken = 1'b0;
   int       send_gap = 0;
   int       ready_gap = 0;
   int       fail_count = 0;

   // predictor state
   longint   probe_x = 0;
   longint   probe_y = 0;
   longint   last_x = 0;
   longint   last_y = 0;
   longint   first_x = 0;
   longint   first_y = 0;
   bit       parity = 1'b0;
   logic [1:0] poly_count = '0;

   point_in_polygon_test_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // sign-extend a bus coordinate
   function automatic longint widen(input logic [FIELD_WIDTH-1:0] v);
      coord_type c;
      c = v[COORD_WIDTH-1:0];
      return c;
   endfunction

   // does the edge from current (xc,yc) to previous (xp,yp) cross the ray
   function automatic bit edge_crosses(input longint xc, input longint yc,
                                       input longint xp, input longint yp);
      logic signed [71:0] ax;
      logic signed [71:0] ady;
      logic signed [71:0] bx;
      logic signed [71:0] by;
      logic signed [71:0] lhs;
      logic signed [71:0] rhs;
      if ((yc > probe_y) == (yp > probe_y)) return 1'b0;
      ax  = probe_x - xc;
      ady = yp - yc;
      bx  = xp - xc;
      by  = probe_y - yc;
      lhs = ax * ady;
      rhs = bx * by;
      if (ady > 0) return lhs < rhs;
      return lhs > rhs;
   endfunction

   // fold one accepted vertex into the running parity
   function automatic void track_vertex(input vertex_type v);
      longint      vx;
      longint      vy;
      logic [1:0]  seen;
      verdict_type verdict;
      vx   = widen(v.x);
      vy   = widen(v.y);
      seen = poly_count;
      if (seen == 2'd0) begin
         first_x = vx;
         first_y = vy;
      end else begin
         parity ^= edge_crosses(vx, vy, last_x, last_y);
      end
      last_x = vx;
      last_y = vy;
      if (poly_count != COUNT_MAX) poly_count++;
      if (v.last) begin
         // closing edge back to the first vertex
         if (seen != 2'd0) parity ^= edge_crosses(first_x, first_y, vx, vy);
         verdict.few     = (seen < COUNT_FEW);
         verdict.in_poly = verdict.few ? 1'b0 : parity;
         expected_verdicts.push_back(verdict);
         parity     = 1'b0;
         poly_count = '0;
      end
   endfunction

   function automatic void flag_error(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t ERROR %s", $realtime, msg);
   endfunction

   // monitor: track accepted transactions at the rising edge
   always @(posedge clock) begin
      vertex_type  v;
      verdict_type want;
      vtx_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TEST_X) probe_x = widen(csr_data);
            else if (csr_index == CSR_TEST_Y) probe_y = widen(csr_data);
         end
         if (req_tvalid && req_tready) begin
            v.x    = req_tdata[FIELD_WIDTH-1:0];
            v.y    = req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH];
            v.last = req_tlast;
            track_vertex(v);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               flag_error($sformatf("unexpected result inside=%0b few=%0b",
                                    rsp_tdata[0], rsp_tdata[1]));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== want.in_poly || rsp_tdata[1] !== want.few)
                  flag_error($sformatf("inside exp %0b got %0b, few exp %0b got %0b",
                                       want.in_poly, rsp_tdata[0], want.few, rsp_tdata[1]));
            end
         end
      end
   end

   // vertex driver, fed from the pending queue
   always @(negedge clock) begin
      vertex_type v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !vtx_taken)) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap   <= $urandom_range(0, 8);
            req_tvalid <= 1'b0;
         end else if (pending_vertices.size() != 0) begin
            v = pending_vertices.pop_front();
            req_tdata  <= {v.y, v.x};
            req_tlast  <= v.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap  <= ready_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         ready_gap  <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [FIELD_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic last);
      vertex_type v;
      v.x    = x;
      v.y    = y;
      v.last = last;
      pending_vertices.push_back(v);
   endtask

   // coordinate scattered around a base, sometimes on it or anywhere at all
   function automatic logic [31:0] scatter(input logic [31:0] base, input int span);
      logic [31:0] r;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return base;
         default: begin
            r = $urandom() >> (32 - span);
            return base + r - (32'd1 << (span - 1));
         end
      endcase
   endfunction

   // one polygon around the query point; returns its vertex count
   task automatic add_random_polygon(input logic [31:0] qx, input logic [31:0] qy,
                                     output int n);
      int          span;
      logic [31:0] y;
      case ($urandom_range(0, 9))
         0:       n = 1;
         1:       n = 2;
         2:       n = $urandom_range(9, 20);
         default: n = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 2))
         0:       span = $urandom_range(2, 8);
         1:       span = $urandom_range(9, 20);
         default: span = $urandom_range(21, 31);
      endcase
      y = qy;
      for (int i = 0; i < n; i++) begin
         // now and then repeat the previous y for a horizontal edge
         if (i == 0 || $urandom_range(0, 7) != 0) y = scatter(qy, span);
         push_vertex(scatter(qx, span), y, i == n - 1);
      end
   endtask

   // hold off until every vertex is in and every verdict has come back
   task automatic wait_drained();
      while (pending_vertices.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [31:0] qx;
      logic [31:0] qy;
      int          total;
      int          n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, query point at its reset value
      push_vertex(MAX_POS, MAX_NEG, 1'b1);                // single vertex
      push_vertex(MAX_NEG, MAX_POS, 1'b0);                // two vertices
      push_vertex(32'd0, 32'd0, 1'b1);
      push_vertex(-ONE, -ONE, 1'b0);                      // square with corners at +/-1 round the origin
      push_vertex(ONE, -ONE, 1'b0);
      push_vertex(ONE, ONE, 1'b0);
      push_vertex(-ONE, ONE, 1'b1);
      push_vertex(-ONE, 32'd0, 1'b0);                     // horizontal edge on the ray
      push_vertex(ONE, 32'd0, 1'b0);
      push_vertex(32'd0, ONE, 1'b1);
      push_vertex(MAX_NEG, MAX_NEG, 1'b0);                // full-range triangle
      push_vertex(MAX_POS, MAX_NEG, 1'b0);
      push_vertex(32'd0, MAX_POS, 1'b1);
      wait_drained();

      // query point at the extremes
      write_reg(CSR_TEST_X, MAX_POS);
      write_reg(CSR_TEST_Y, MAX_NEG);
      push_vertex(MAX_NEG, MAX_NEG, 1'b0);
      push_vertex(MAX_POS, MAX_POS, 1'b0);
      push_vertex(MAX_NEG, MAX_POS, 1'b1);
      push_vertex(-ONE, -ONE, 1'b0);
      push_vertex(ONE, -ONE, 1'b0);
      push_vertex(ONE, ONE, 1'b0);
      push_vertex(-ONE, ONE, 1'b1);
      wait_drained();
      write_reg(CSR_TEST_X, MAX_NEG);
      write_reg(CSR_TEST_Y, MAX_POS);
      push_vertex(MAX_POS, MAX_NEG, 1'b0);
      push_vertex(MAX_POS, MAX_POS, 1'b0);
      push_vertex(MAX_NEG, 32'd0, 1'b1);
      wait_drained();

      // random polygons, one query point per phase; the last phase runs flat out
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if ($urandom_range(0, 3) == 0) begin
            qx = $urandom();
            qy = $urandom();
         end else begin
            qx = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
            qy = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
         end
         write_reg(CSR_TEST_X, qx);
         write_reg(CSR_TEST_Y, qy);
         calm  = (ph == RANDOM_PHASES - 1);
         total = 0;
         while (total < PHASE_VERTICES) begin
            add_random_polygon(qx, qy, n);
            total += n;
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
